/* rtl/owik_pkg.sv */
package owik_pkg;

    // Fixed point: velocity Q4.12 times Q0.16 constants gives wheel sums in Q.28
    localparam int SUM_W       = 36;
    localparam int MUL_B_W     = 17;
    localparam int PROD_W      = SUM_W + MUL_B_W;
    localparam int ROUND_SHIFT = 28;

    localparam logic [15:0] K_SIN60    = 16'd56756;
    localparam logic [15:0] K_INVSQRT2 = 16'd46341;

    // Configuration register indexes
    localparam logic [1:0] CFG_WHEEL_MODE       = 2'd0;
    localparam logic [1:0] CFG_CENTER_DISTANCE  = 2'd1;
    localparam logic [1:0] CFG_INV_WHEEL_RADIUS = 2'd2;
    localparam logic [1:0] CFG_MAX_WHEEL_RATE   = 2'd3;

    localparam logic        RST_WHEEL_MODE       = 1'b1;
    localparam logic [15:0] RST_CENTER_DISTANCE  = 16'd26214;
    localparam logic [15:0] RST_INV_WHEEL_RADIUS = 16'd5039;
    localparam logic [14:0] RST_MAX_WHEEL_RATE   = 15'd12800;

    typedef enum logic [1:0] {
        MUL_ROT,
        MUL_LIN,
        MUL_SCALE
    } mul_op_t;

    typedef struct packed {
        logic      load_in;
        logic      mul_en;
        mul_op_t   op;
        logic [1:0] wheel;
        logic      load_out;
        logic      stop;
    } owik_cmd_t;

endpackage

/* rtl/owik_ctrl.sv */
module owik_ctrl
    import owik_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_tick,
    output logic      in_ready,
    input  logic      wheel_mode,
    input  logic      out_ready,
    output logic      out_valid,
    output owik_cmd_t cmd
);

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        FLUSH,
        LOAD
    } state_t;

    localparam logic [3:0] STEP_ROT     = 4'd0;
    localparam logic [3:0] STEP_LIN2    = 4'd3;
    localparam logic [3:0] STEP_LIN_END = 4'd4;
    localparam logic [3:0] STEP_SCALE0  = 4'd5;
    localparam logic [3:0] STEP_SCALE2  = 4'd7;
    localparam logic [3:0] STEP_SCALE3  = 4'd8;

    state_t     state_reg;
    logic [3:0] step_reg;
    logic       out_valid_reg;
    logic       seen_reg;
    logic       stop_reg;

    logic       accept;
    logic [3:0] step_lin;
    logic [3:0] step_scale;

    assign in_ready   = (state_reg == IDLE);
    assign out_valid  = out_valid_reg;
    assign accept     = in_valid && (state_reg == IDLE);
    assign step_lin   = step_reg - 4'd1;
    assign step_scale = step_reg - STEP_SCALE0;

    always_comb
    begin
        cmd          = '0;
        cmd.op       = MUL_ROT;
        cmd.load_in  = accept;
        cmd.stop     = stop_reg;
        cmd.load_out = (state_reg == LOAD) && (!out_valid_reg || out_ready);
        if (state_reg == RUN)
        begin
            cmd.mul_en = 1'b1;
            if (step_reg == STEP_ROT)
            begin
                cmd.op    = MUL_ROT;
                cmd.wheel = 2'd0;
            end
            else if (step_reg <= STEP_LIN_END)
            begin
                cmd.op    = MUL_LIN;
                cmd.wheel = step_lin[1:0];
            end
            else
            begin
                cmd.op    = MUL_SCALE;
                cmd.wheel = step_scale[1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            step_reg      <= STEP_ROT;
            out_valid_reg <= 1'b0;
            seen_reg      <= 1'b0;
            stop_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        if (in_tick)
                        begin
                            // a tick always clears the flag; stop only if nothing came
                            seen_reg <= 1'b0;
                            stop_reg <= 1'b1;
                            if (!seen_reg)
                                state_reg <= LOAD;
                        end
                        else
                        begin
                            seen_reg  <= 1'b1;
                            stop_reg  <= 1'b0;
                            step_reg  <= STEP_ROT;
                            state_reg <= RUN;
                        end
                    end
                end
                RUN:
                begin
                    if ((step_reg == STEP_SCALE3) ||
                        ((step_reg == STEP_SCALE2) && !wheel_mode))
                        state_reg <= FLUSH;
                    else if ((step_reg == STEP_LIN2) && !wheel_mode)
                        step_reg <= STEP_SCALE0;
                    else
                        step_reg <= step_reg + 4'd1;
                end
                FLUSH:
                begin
                    state_reg <= LOAD;
                end
                LOAD:
                begin
                    if (cmd.load_out)
                        state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/owik_dp.sv */
module owik_dp
    import owik_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  owik_cmd_t          cmd,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    input  logic signed [15:0] yaw_rate,
    input  logic               wheel_mode,
    input  logic [15:0]        center_distance,
    input  logic [15:0]        inv_wheel_radius,
    input  logic [14:0]        max_wheel_rate,
    output logic signed [15:0] rate_0,
    output logic signed [15:0] rate_1,
    output logic signed [15:0] rate_2,
    output logic signed [15:0] rate_3,
    output logic [2:0]         wheel_count,
    output logic               timeout_stop
);

    logic signed [15:0]       vx_reg;
    logic signed [15:0]       vy_reg;
    logic signed [15:0]       w_reg;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;
    logic                     post_valid_reg;
    mul_op_t                  post_op_reg;
    logic [1:0]               post_wheel_reg;
    logic signed [SUM_W-1:0]  rot_reg;
    logic signed [SUM_W-1:0]  sum_reg [4];
    logic signed [15:0]       rate_reg [4];

    logic signed [15:0]       out_rate_reg [4];
    logic [2:0]               count_reg;
    logic                     stop_reg;

    logic signed [17:0]        vx_e;
    logic signed [17:0]        vy_e;
    logic signed [17:0]        lin_a;
    logic signed [SUM_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [SUM_W-1:0]   lin_off;
    logic signed [SUM_W-1:0]   lin_sum;
    logic [PROD_W-1:0]         mag;
    logic [PROD_W-1:0]         mag_rnd;
    logic [PROD_W-ROUND_SHIFT-1:0] rounded;
    logic [14:0]               clamped;
    logic signed [15:0]        scaled;
    logic signed [17:0]        neg_vx;

    assign vx_e   = {{2{vx_reg[15]}}, vx_reg};
    assign vy_e   = {{2{vy_reg[15]}}, vy_reg};
    assign neg_vx = -vx_e;

    // Multiplier operand selection
    always_comb
    begin
        lin_a = vy_e;
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            MUL_ROT:
            begin
                mul_a = {{(SUM_W-16){w_reg[15]}}, w_reg};
                mul_b = {1'b0, center_distance};
            end
            MUL_LIN:
            begin
                if (wheel_mode)
                begin
                    case (cmd.wheel)
                        2'd0:    lin_a = vy_e - vx_e;
                        2'd1:    lin_a = -vx_e - vy_e;
                        2'd2:    lin_a = vx_e - vy_e;
                        default: lin_a = vx_e + vy_e;
                    endcase
                    mul_b = {1'b0, K_INVSQRT2};
                end
                else
                begin
                    case (cmd.wheel)
                        2'd0:
                        begin
                            lin_a = vy_e;
                            mul_b = {1'b0, K_SIN60};
                        end
                        2'd1:
                        begin
                            lin_a = -vy_e;
                            mul_b = {1'b0, K_SIN60};
                        end
                        default:
                        begin
                            // wheel 2 takes vx straight through the offset term
                            lin_a = vx_e;
                            mul_b = '0;
                        end
                    endcase
                end
                mul_a = {{(SUM_W-18){lin_a[17]}}, lin_a};
            end
            MUL_SCALE:
            begin
                mul_a = sum_reg[cmd.wheel];
                mul_b = {1'b0, inv_wheel_radius};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign p_next = mul_a * mul_b;

    // Post-processing of the registered product
    always_comb
    begin
        lin_off = '0;
        if (!wheel_mode)
        begin
            if (post_wheel_reg == 2'd2)
                lin_off = {{(SUM_W-32){vx_reg[15]}}, vx_reg, 16'b0};
            else if (post_wheel_reg != 2'd3)
                lin_off = {{(SUM_W-33){neg_vx[17]}}, neg_vx, 15'b0};
        end
    end

    assign lin_sum = p_reg[SUM_W-1:0] + lin_off + rot_reg;

    assign mag     = p_reg[PROD_W-1] ? PROD_W'(-p_reg) : PROD_W'(p_reg);
    assign mag_rnd = mag + (PROD_W'(1) << (ROUND_SHIFT - 1));
    assign rounded = mag_rnd[PROD_W-1:ROUND_SHIFT];

    always_comb
    begin
        if (rounded > {{(PROD_W-ROUND_SHIFT-15){1'b0}}, max_wheel_rate})
            clamped = max_wheel_rate;
        else
            clamped = rounded[14:0];
        if (p_reg[PROD_W-1])
            scaled = -$signed({1'b0, clamped});
        else
            scaled = $signed({1'b0, clamped});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            post_valid_reg <= 1'b0;
        else
            post_valid_reg <= cmd.mul_en;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            vx_reg <= vel_x;
            vy_reg <= vel_y;
            w_reg  <= yaw_rate;
        end
        if (cmd.mul_en)
        begin
            p_reg          <= p_next;
            post_op_reg    <= cmd.op;
            post_wheel_reg <= cmd.wheel;
        end
        if (post_valid_reg)
        begin
            case (post_op_reg)
                MUL_ROT:   rot_reg                  <= p_reg[SUM_W-1:0];
                MUL_LIN:   sum_reg[post_wheel_reg]  <= lin_sum;
                MUL_SCALE: rate_reg[post_wheel_reg] <= scaled;
                default:   rot_reg                  <= rot_reg;
            endcase
        end
        if (cmd.load_out)
        begin
            stop_reg  <= cmd.stop;
            count_reg <= wheel_mode ? 3'd4 : 3'd3;
            for (int i = 0; i < 4; i++)
            begin
                if (cmd.stop || ((i == 3) && !wheel_mode))
                    out_rate_reg[i] <= '0;
                else
                    out_rate_reg[i] <= rate_reg[i];
            end
        end
    end

    assign rate_0       = out_rate_reg[0];
    assign rate_1       = out_rate_reg[1];
    assign rate_2       = out_rate_reg[2];
    assign rate_3       = out_rate_reg[3];
    assign wheel_count  = count_reg;
    assign timeout_stop = stop_reg;

endmodule

/* rtl/omni_wheel_inverse_kinematics.sv */
// Velocity command: the single shared multiplier forms the yaw term, each linear term and
// each scaling in turn, then the result is loaded; a new command is accepted only once the
// result has been loaded into the output register.
// Tick: input stays ready, or returns to ready once the stop result it issues is loaded.
// Reset (rst_n low, asynchronous) clears the sequencer, output valid and the command flag,
// and returns all configuration registers to their defaults.
module omni_wheel_inverse_kinematics
    import owik_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // vel_x[15:0], vel_y[31:16], yaw_rate[47:32]
    input  logic        s_axis_tuser,   // tick[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // rate_0..rate_3[63:0], wheel_count[66:64], zero
    output logic        m_axis_tuser,   // timeout_stop[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        wheel_mode_reg;
    logic [15:0] center_distance_reg;
    logic [15:0] inv_wheel_radius_reg;
    logic [14:0] max_wheel_rate_reg;

    owik_cmd_t          cmd;
    logic signed [15:0] rate_0;
    logic signed [15:0] rate_1;
    logic signed [15:0] rate_2;
    logic signed [15:0] rate_3;
    logic [2:0]         wheel_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_mode_reg       <= RST_WHEEL_MODE;
            center_distance_reg  <= RST_CENTER_DISTANCE;
            inv_wheel_radius_reg <= RST_INV_WHEEL_RADIUS;
            max_wheel_rate_reg   <= RST_MAX_WHEEL_RATE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WHEEL_MODE:       wheel_mode_reg       <= cfg_data[0];
                CFG_CENTER_DISTANCE:  center_distance_reg  <= cfg_data;
                CFG_INV_WHEEL_RADIUS: inv_wheel_radius_reg <= cfg_data;
                CFG_MAX_WHEEL_RATE:   max_wheel_rate_reg   <= cfg_data[14:0];
                default:              wheel_mode_reg       <= wheel_mode_reg;
            endcase
        end
    end

    owik_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_tick    (s_axis_tuser),
        .in_ready   (s_axis_tready),
        .wheel_mode (wheel_mode_reg),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .cmd        (cmd)
    );

    owik_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .vel_x            (s_axis_tdata[15:0]),
        .vel_y            (s_axis_tdata[31:16]),
        .yaw_rate         (s_axis_tdata[47:32]),
        .wheel_mode       (wheel_mode_reg),
        .center_distance  (center_distance_reg),
        .inv_wheel_radius (inv_wheel_radius_reg),
        .max_wheel_rate   (max_wheel_rate_reg),
        .rate_0           (rate_0),
        .rate_1           (rate_1),
        .rate_2           (rate_2),
        .rate_3           (rate_3),
        .wheel_count      (wheel_count),
        .timeout_stop     (m_axis_tuser)
    );

    assign m_axis_tdata = {5'b0, wheel_count, rate_3, rate_2, rate_1, rate_0};

    // A velocity command keeps the sequencer busy for the next cycle
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> !s_axis_tready)
        else $error("input ready right after a velocity command");

    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("watchdog stop result carries nonzero rates");

    a_three_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[66:64] == 3'd3)) |-> (m_axis_tdata[63:48] == 16'd0))
        else $error("rate_3 nonzero in three-wheel result");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[66:64] == 3'd3) || (m_axis_tdata[66:64] == 3'd4)))
        else $error("wheel count out of range");

endmodule
